// ===== hdl/usbf_pkg.sv =====
// ----------------------------------------------------------------------------
// usbf_pkg
// shared types, class codes and the code point classifier
// ----------------------------------------------------------------------------
package usbf_pkg;

  localparam int OUT_BITS = 24;

  typedef enum logic [3:0] {
    CL_OTHER   = 4'd0,
    CL_CR      = 4'd1,
    CL_LF      = 4'd2,
    CL_SEP     = 4'd3,
    CL_EXTEND  = 4'd4,
    CL_FORMAT  = 4'd5,
    CL_SP      = 4'd6,
    CL_LOWER   = 4'd7,
    CL_UPPER   = 4'd8,
    CL_OLETTER = 4'd9,
    CL_ATERM   = 4'd10,
    CL_STERM   = 4'd11,
    CL_CLOSE   = 4'd12
  } cls_t;

  typedef enum logic [1:0] {
    AN_NONE  = 2'd0,
    AN_ATERM = 2'd1,
    AN_STERM = 2'd2
  } anchor_t;

  // one decoded item between the front and the back
  typedef struct packed {
    logic        is_end;
    logic [20:0] cp;
    logic [2:0]  used;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] offset;
    logic                is_end;
    logic                last;
  } res_t;

  function automatic logic rng(input logic [20:0] v, input logic [20:0] lo,
                               input logic [20:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic cls_t class_of(input logic [20:0] v);
    cls_t c;
    c = CL_OTHER;
    if (v == 21'h0d) c = CL_CR;
    else if (v == 21'h0a) c = CL_LF;
    else if (v == 21'h0b || v == 21'h0c || v == 21'h85 || rng(v, 21'h2028, 21'h2029))
      c = CL_SEP;
    else if (v == 21'h20) c = CL_SP;
    else if (v == 21'h2e || v == 21'h2024 || v == 21'hfe52 || v == 21'hff0e) c = CL_ATERM;
    else if (v == 21'h21 || v == 21'h3f || v == 21'h3002 || v == 21'hff01 ||
             v == 21'hff1f) c = CL_STERM;
    else if (v == 21'h29 || v == 21'h5d || v == 21'h7d || v == 21'h27 || v == 21'h22 ||
             v == 21'hbb || v == 21'h2019 || v == 21'h201d) c = CL_CLOSE;
    else if (v == 21'h200c || v == 21'h200d || rng(v, 21'h300, 21'h36f) ||
             rng(v, 21'h1ab0, 21'h1aff) || rng(v, 21'h1dc0, 21'h1dff) ||
             rng(v, 21'h20d0, 21'h20ff) || rng(v, 21'hfe00, 21'hfe0f)) c = CL_EXTEND;
    else if (v == 21'had || v == 21'h61c || rng(v, 21'h200e, 21'h200f) ||
             rng(v, 21'h202a, 21'h202e) || rng(v, 21'h2060, 21'h2064) ||
             v == 21'hfeff) c = CL_FORMAT;
    else if (rng(v, 21'h61, 21'h7a) || rng(v, 21'he0, 21'hf6) || rng(v, 21'hf8, 21'hff))
      c = CL_LOWER;
    else if (rng(v, 21'h41, 21'h5a) || rng(v, 21'hc0, 21'hd6) || rng(v, 21'hd8, 21'hde))
      c = CL_UPPER;
    else if (rng(v, 21'h370, 21'h52f) || rng(v, 21'h531, 21'h1fff) ||
             rng(v, 21'h3040, 21'h30ff) || rng(v, 21'h3400, 21'h9fff) ||
             rng(v, 21'hac00, 21'hd7af) || rng(v, 21'hf900, 21'hfaff) ||
             rng(v, 21'h10000, 21'h10ffff)) c = CL_OLETTER;
    return c;
  endfunction

endpackage

// ===== hdl/usbf_front.sv =====
// ----------------------------------------------------------------------------
// usbf_front
// byte buffer and utf-8 decoder, one token per cycle while the token queue has room
// ----------------------------------------------------------------------------
module usbf_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_text_byte,
  input  logic            in_final_byte,
  output logic            tok_valid,
  input  logic            tok_full,
  output usbf_pkg::token_t tok
);
  import usbf_pkg::*;

  logic [7:0] pend_r [4];
  logic [7:0] pend_nxt [4];
  logic [2:0] cnt_r, cnt_nxt;
  logic       fin_r, fin_nxt;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] l;
    l = 3'd1;
    if (b >= 8'hc2 && b <= 8'hdf) l = 3'd2;
    else if (b >= 8'he0 && b <= 8'hef) l = 3'd3;
    else if (b >= 8'hf0 && b <= 8'hf4) l = 3'd4;
    return l;
  endfunction

  function automatic logic can_dec(input logic [7:0] b0, input logic [2:0] n,
                                   input logic fin);
    logic [2:0] l;
    l = lead_len(b0);
    return (n != 3'd0) && ((l == 3'd1) || (n >= l) || fin);
  endfunction

  logic       dec, end_pend, accept, step;
  logic [2:0] len, used;
  logic [20:0] v, cp;
  logic       ok;

  assign dec      = can_dec(pend_r[0], cnt_r, fin_r);
  assign end_pend = fin_r && (cnt_r == 3'd0);
  assign in_stall = dec || end_pend;
  assign accept   = in_valid && !in_stall;
  assign step     = (dec || end_pend) && !tok_full;
  assign len      = lead_len(pend_r[0]);

  always_comb begin
    v  = 21'd0;
    ok = 1'b1;
    case (len)
      3'd2: begin
        v  = {10'd0, pend_r[0][4:0], pend_r[1][5:0]};
        ok = (pend_r[1][7:6] == 2'b10);
      end
      3'd3: begin
        v  = {5'd0, pend_r[0][3:0], pend_r[1][5:0], pend_r[2][5:0]};
        ok = (pend_r[1][7:6] == 2'b10) && (pend_r[2][7:6] == 2'b10);
      end
      3'd4: begin
        v  = {pend_r[0][2:0], pend_r[1][5:0], pend_r[2][5:0], pend_r[3][5:0]};
        ok = (pend_r[1][7:6] == 2'b10) && (pend_r[2][7:6] == 2'b10) &&
             (pend_r[3][7:6] == 2'b10);
      end
      default: begin
        v  = 21'd0;
        ok = 1'b0;
      end
    endcase
    // surrogates are rejected, 21 bits cover everything else above range
    ok = ok && (v <= 21'h10ffff) && !((v >= 21'hd800) && (v <= 21'hdfff));
    if (len != 3'd1 && cnt_r >= len && ok) begin
      cp   = v;
      used = len;
    end else begin
      cp   = {13'd0, pend_r[0]};
      used = 3'd1;
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    fin_nxt  = fin_r;
    tok      = '0;
    tok_valid = 1'b0;
    if (step && dec) begin
      case (used)
        3'd1: begin
          pend_nxt[0] = pend_r[1];
          pend_nxt[1] = pend_r[2];
          pend_nxt[2] = pend_r[3];
        end
        3'd2: begin
          pend_nxt[0] = pend_r[2];
          pend_nxt[1] = pend_r[3];
        end
        3'd3: pend_nxt[0] = pend_r[3];
        default: pend_nxt[0] = pend_r[0];
      endcase
      cnt_nxt   = cnt_r - used;
      tok_valid = 1'b1;
      tok.is_end = 1'b0;
      tok.cp    = cp;
      tok.used  = used;
      tok.last  = !fin_r && !can_dec(pend_nxt[0], cnt_nxt, 1'b0);
    end else if (step && end_pend) begin
      tok_valid  = 1'b1;
      tok.is_end = 1'b1;
      tok.last   = 1'b1;
      fin_nxt    = 1'b0;
    end else if (accept) begin
      pend_nxt[cnt_r[1:0]] = in_text_byte;
      cnt_nxt = cnt_r + 3'd1;
      fin_nxt = in_final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      fin_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      fin_r <= fin_nxt;
    end
    pend_r <= pend_nxt;
  end

endmodule

// ===== hdl/usbf_queue.sv =====
// ----------------------------------------------------------------------------
// usbf_queue
// two-entry token queue between decoder and boundary logic
// ----------------------------------------------------------------------------
module usbf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  usbf_pkg::token_t wr_tok,
  output logic             full,
  output logic             rd_valid,
  input  logic             rd_en,
  output usbf_pkg::token_t rd_tok
);
  import usbf_pkg::*;

  token_t     mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_tok   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= !wp_r;
      if (rd_en) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
    if (wr_en) mem_r[wp_r] <= wr_tok;
  end

endmodule

// ===== hdl/usbf_back.sv =====
// ----------------------------------------------------------------------------
// usbf_back
// sentence break rules, offset tracking and result queue
// ----------------------------------------------------------------------------
module usbf_back #(
  parameter int OFFSET_BITS = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [2:0]       limit,
  input  logic             tok_valid,
  input  usbf_pkg::token_t tok,
  output logic             tok_take,
  output logic             out_valid,
  input  logic             out_stall,
  output usbf_pkg::res_t   res
);
  import usbf_pkg::*;

  logic [OFFSET_BITS-1:0] pos_r, pos_nxt, lem_r, lem_nxt;
  cls_t    prev_r, prev_nxt;
  anchor_t anc_r, anc_nxt;
  logic [2:0] run_r, run_nxt, wbt_r, wbt_nxt;
  logic    seen_r, seen_nxt;
  logic    hv_r, hv_nxt, hend_r, hend_nxt;
  logic [OUT_BITS-1:0] hoff_r, hoff_nxt;

  res_t       q_r [2];
  logic       qw_r, qr_r;
  logic [1:0] qc_r;

  cls_t c;
  logic letter, skip, brk, emit;
  logic [OUT_BITS-1:0] off_out;
  logic [47:0] pos_ext;
  logic [OFFSET_BITS:0] sum;
  logic push_a, push_b, pop;
  logic [2:0] need, room;
  res_t ra, rb;

  assign pos_ext = 48'(pos_r);
  assign off_out = pos_ext[OUT_BITS-1:0];
  assign c       = class_of(tok.cp);
  assign letter  = (c == CL_LOWER) || (c == CL_UPPER) || (c == CL_OLETTER);
  assign skip    = (c == CL_SP) || (c == CL_CLOSE) || (c == CL_EXTEND) || (c == CL_FORMAT);

  always_comb begin
    brk = 1'b0;
    if (prev_r == CL_CR && c == CL_LF) brk = 1'b0;
    else if (prev_r == CL_CR || prev_r == CL_LF || prev_r == CL_SEP) brk = 1'b1;
    else if (c == CL_EXTEND || c == CL_FORMAT) brk = 1'b0;
    else if (anc_r == AN_NONE || !letter) brk = 1'b0;
    else if (anc_r == AN_ATERM) brk = (wbt_r > limit) && (c != CL_LOWER);
    else brk = 1'b1;
  end

  assign emit = tok.is_end ? (!seen_r || pos_r != lem_r) : (!seen_r || brk);

  // a held result waits until it is known whether it closes its byte's run
  assign push_a = emit && hv_r;
  assign push_b = tok.last && (hv_r || emit);
  assign need   = {2'd0, push_a} + {2'd0, push_b};
  assign pop    = out_valid && !out_stall;
  assign room   = 3'd2 - {1'b0, qc_r} + {2'd0, pop};
  assign tok_take = tok_valid && (need <= room);

  assign ra.offset = hoff_r;
  assign ra.is_end = hend_r;
  assign ra.last   = 1'b0;
  assign rb.offset = emit ? off_out : hoff_r;
  assign rb.is_end = emit ? tok.is_end : hend_r;
  assign rb.last   = 1'b1;

  assign sum = {1'b0, pos_r} + (OFFSET_BITS + 1)'(tok.used);

  always_comb begin
    pos_nxt  = pos_r;
    lem_nxt  = lem_r;
    prev_nxt = prev_r;
    anc_nxt  = anc_r;
    run_nxt  = run_r;
    wbt_nxt  = wbt_r;
    seen_nxt = seen_r;
    hv_nxt   = hv_r;
    hend_nxt = hend_r;
    hoff_nxt = hoff_r;
    if (tok_take) begin
      if (emit) begin
        lem_nxt  = pos_r;
        hv_nxt   = 1'b1;
        hoff_nxt = off_out;
        hend_nxt = tok.is_end;
      end
      if (tok.last) hv_nxt = 1'b0;
      if (tok.is_end) begin
        pos_nxt  = '0;
        lem_nxt  = '0;
        prev_nxt = CL_OTHER;
        anc_nxt  = AN_NONE;
        run_nxt  = 3'd0;
        wbt_nxt  = 3'd0;
        seen_nxt = 1'b0;
      end else begin
        seen_nxt = 1'b1;
        if (c == CL_ATERM || c == CL_STERM) begin
          anc_nxt = (c == CL_ATERM) ? AN_ATERM : AN_STERM;
          wbt_nxt = run_r;
        end else if (!skip) begin
          anc_nxt = AN_NONE;
        end
        if (letter) run_nxt = (run_r == 3'd7) ? run_r : run_r + 3'd1;
        else run_nxt = 3'd0;
        prev_nxt = c;
        pos_nxt  = sum[OFFSET_BITS] ? '1 : sum[OFFSET_BITS-1:0];
      end
    end
  end

  assign out_valid = (qc_r != 2'd0);
  assign res       = q_r[qr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      lem_r  <= '0;
      prev_r <= CL_OTHER;
      anc_r  <= AN_NONE;
      run_r  <= 3'd0;
      wbt_r  <= 3'd0;
      seen_r <= 1'b0;
      hv_r   <= 1'b0;
      qw_r   <= 1'b0;
      qr_r   <= 1'b0;
      qc_r   <= 2'd0;
    end else begin
      pos_r  <= pos_nxt;
      lem_r  <= lem_nxt;
      prev_r <= prev_nxt;
      anc_r  <= anc_nxt;
      run_r  <= run_nxt;
      wbt_r  <= wbt_nxt;
      seen_r <= seen_nxt;
      hv_r   <= hv_nxt;
      if (pop) qr_r <= !qr_r;
      if (tok_take) qw_r <= qw_r ^ (push_a ^ push_b);
      qc_r <= qc_r + (tok_take ? need[1:0] : 2'd0) - {1'b0, pop};
    end
    hend_r <= hend_nxt;
    hoff_r <= hoff_nxt;
    if (tok_take) begin
      if (push_a) q_r[qw_r] <= ra;
      if (push_b) q_r[push_a ? !qw_r : qw_r] <= rb;
    end
  end

endmodule

// ===== hdl/utf8_sentence_boundary_finder_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_sentence_boundary_finder_unit
// utf-8 sentence boundary finder: decodes text bytes and reports the byte
// offsets of sentence boundaries
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  input    | in_valid / in_stall    | in_text_byte, in_final_byte
//  result   | out_valid / out_stall  | out_boundary_offset, out_is_text_end,
//           |                        | out_last_of_run
//  config   | psel/penable/pwrite    | paddr, pwdata, prdata (short_word_limit)
//
// every byte is accepted while in_stall is low; each code point it releases
// is then decoded with in_stall high, and the final byte also releases an
// end marker
// the decoder makes one token per cycle while the token queue has room; the
// rule stage takes one per cycle as long as its two-entry result queue has room
// reset is synchronous, active low, and clears all control state
// a stalled result side backs up through the token queue into in_stall
module utf8_sentence_boundary_finder_unit #(
  parameter int OFFSET_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_boundary_offset,
  output logic        out_is_text_end,
  output logic        out_last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import usbf_pkg::*;

  logic [2:0] limit_r;
  logic       cfg_wr;

  // token path between decoder, queue and rule stage
  logic   f_valid, q_full, q_valid, q_take;
  token_t f_tok, q_tok;
  res_t   res;

  // register 0 at byte address 0; other addresses read as zero
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
  assign prdata = (paddr == 3'd0) ? {29'd0, limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 3'd2;
    end else if (cfg_wr) begin
      limit_r <= pwdata[2:0];
    end
  end

  usbf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_text_byte  (in_text_byte),
    .in_final_byte (in_final_byte),
    .tok_valid     (f_valid),
    .tok_full      (q_full),
    .tok           (f_tok)
  );

  usbf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (f_valid),
    .wr_tok   (f_tok),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_en    (q_take),
    .rd_tok   (q_tok)
  );

  usbf_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .limit     (limit_r),
    .tok_valid (q_valid),
    .tok       (q_tok),
    .tok_take  (q_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_boundary_offset = res.offset;
  assign out_is_text_end     = res.is_end;
  assign out_last_of_run     = res.last;

endmodule
